// ----- design/shamu_pkg.sv -----
// ----------------------------------------------------------------------------
// shamu_pkg: shared types and constants of the sensor history alert monitor
// Beat layouts, register indexes, reset values and the control states.
// ----------------------------------------------------------------------------
package shamu_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSECUTIVE_COUNT = 2'd2;

    localparam logic signed [7:0] HOT_THRESHOLD_RST     = 8'sd35;
    localparam logic [6:0]        WINDOW_COUNT_RST      = 7'd15;
    localparam logic [6:0]        CONSECUTIVE_COUNT_RST = 7'd5;
    localparam logic [6:0]        RECORDS_CAP           = 7'd64;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [1:0] ALERT_NONE   = 2'd0;
    localparam logic [1:0] ALERT_NORMAL = 2'd1;
    localparam logic [1:0] ALERT_YELLOW = 2'd2;
    localparam logic [1:0] ALERT_RED    = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [7:0]        sensor_id;
        logic signed [7:0] temperature;
    } input_item_t;

    typedef struct packed {
        logic              has_average;
        logic signed [7:0] average;
        logic [1:0]        alert_level;
        logic [6:0]        hot_count;
        logic [6:0]        found_count;
    } result_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ----- design/shamu_div.sv -----
// ----------------------------------------------------------------------------
// shamu_div: signed sum over unsigned count, truncated toward zero
// Restoring divider on the magnitude, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module shamu_div
    import shamu_pkg::*;
#(
    parameter int SUM_W = 21,
    parameter int CNT_W = 13
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [7:0]       quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  dvd_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic              neg_reg;

    logic [CNT_W:0]    rem_sh;
    logic              fits;
    logic [CNT_W:0]    rem_next;
    logic [8:0]        mag;
    logic [8:0]        q_signed;

    assign rem_sh   = {rem_reg[CNT_W-1:0], dvd_reg[SUM_W-1]};
    assign fits     = rem_sh >= {1'b0, div_reg};
    assign rem_next = fits ? rem_sh - {1'b0, div_reg} : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            neg_reg <= dividend[SUM_W-1];
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    // |quotient| never exceeds 128, so nine bits carry it
    assign mag      = dvd_reg[8:0];
    assign q_signed = neg_reg ? 9'(-mag) : mag;
    assign quotient = q_signed[7:0];
    assign done     = done_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divide done without a finished run");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg != '0)
        else $error("divider busy with no steps left");
`endif

endmodule

// ----- design/sensor_history_alert_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// sensor_history_alert_monitor_unit: ring store of sensor readings with alerts
// Record beat: writes the store slot at the write pointer.
// Query beat: store scan (one slot read a cycle), divide, then result load; no
// new beat is accepted until the result is loaded, and the load waits while
// out_stall holds back a pending result.
// Reset clears pointer, fill count, record count and valid flags, and loads the config reset values; no sweep.
// ----------------------------------------------------------------------------
module sensor_history_alert_monitor_unit
    import shamu_pkg::*;
#(
    parameter int STORE_DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  input_item_t          in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output result_item_t         out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int FILL_W = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 8;
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(STORE_DEPTH);

    logic [15:0] mem [STORE_DEPTH];

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]       wp_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic [6:0]              records_reg;
    logic signed [7:0]       thr_reg;
    logic [6:0]              window_reg;
    logic [6:0]              consec_reg;

    logic [7:0]              id_reg;
    logic [ADDR_W-1:0]       scan_addr_reg;
    logic [FILL_W-1:0]       scan_cnt_reg;
    logic                    rd_pend_reg;
    logic                    rd_slot_ok_reg;
    logic [15:0]             rd_data_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [FILL_W-1:0]       count_reg;
    logic [6:0]              found_reg;
    logic [6:0]              hot_reg;
    logic [6:0]              streak_reg;
    logic                    run_reg;

    logic                    out_valid_reg;
    result_item_t            out_data_reg, out_data_next;

    logic              in_accept;
    logic              rec_accept;
    logic              qry_accept;
    logic              issue_rd;
    logic              scan_end;
    logic              load_out;
    logic              div_done;
    logic signed [7:0] div_quot;
    logic signed [7:0] rd_temp;
    logic              match;
    logic              in_window;
    logic              is_hot;
    logic              checked;
    logic [1:0]        level;

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (qry_accept)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (scan_end)
                    state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_DONE;
            ST_DONE:
                if (load_out)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        issue_rd = 1'b0;
        scan_end = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                in_stall = 1'b0;
            ST_SCAN:
            begin
                issue_rd = scan_cnt_reg < DEPTH_FILL;
                scan_end = (scan_cnt_reg == DEPTH_FILL) && !rd_pend_reg;
            end
            ST_DIV:
                ;
            ST_DONE:
                load_out = !out_valid_reg || !out_stall;
            default:
                ;
        endcase
    end

    assign in_accept  = in_valid && !in_stall;
    assign rec_accept = in_accept && (in_data.kind == KIND_RECORD);
    assign qry_accept = in_accept && (in_data.kind == KIND_QUERY);
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            fill_reg    <= '0;
            records_reg <= '0;
            thr_reg     <= HOT_THRESHOLD_RST;
            window_reg  <= WINDOW_COUNT_RST;
            consec_reg  <= CONSECUTIVE_COUNT_RST;
            rd_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= issue_rd;
            if (rec_accept)
            begin
                wp_reg <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
                if (fill_reg != DEPTH_FILL)
                    fill_reg <= fill_reg + 1'b1;
                if (records_reg != RECORDS_CAP)
                    records_reg <= records_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_HOT_THRESHOLD:     thr_reg    <= cfg_data;
                    CFG_WINDOW_COUNT:      window_reg <= cfg_data[6:0];
                    CFG_CONSECUTIVE_COUNT: consec_reg <= cfg_data[6:0];
                    default:               ;
                endcase
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- store ----------------
    always_ff @(posedge clk)
    begin
        if (rec_accept)
            mem[wp_reg] <= {in_data.sensor_id, in_data.temperature};
        if (issue_rd)
            rd_data_reg <= mem[scan_addr_reg];
    end

    // ---------------- scan, newest slot first ----------------
    assign rd_temp   = rd_data_reg[7:0];
    assign match     = rd_pend_reg && rd_slot_ok_reg && (rd_data_reg[15:8] == id_reg);
    assign in_window = found_reg < window_reg;
    assign is_hot    = rd_temp > thr_reg;

    always_ff @(posedge clk)
    begin
        if (qry_accept)
        begin
            id_reg        <= in_data.sensor_id;
            scan_addr_reg <= (wp_reg == '0) ? LAST_ADDR : wp_reg - 1'b1;
            scan_cnt_reg  <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            found_reg     <= '0;
            hot_reg       <= '0;
            streak_reg    <= '0;
            run_reg       <= 1'b1;
        end
        else
        begin
            if (issue_rd)
            begin
                // filled slots are always the low ones: the pointer wraps only when full
                rd_slot_ok_reg <= FILL_W'(scan_addr_reg) < fill_reg;
                scan_addr_reg  <= (scan_addr_reg == '0) ? LAST_ADDR : scan_addr_reg - 1'b1;
                scan_cnt_reg   <= scan_cnt_reg + 1'b1;
            end
            if (match)
            begin
                sum_reg   <= sum_reg + SUM_W'(rd_temp);
                count_reg <= count_reg + 1'b1;
                if (in_window)
                begin
                    found_reg <= found_reg + 1'b1;
                    if (is_hot)
                    begin
                        hot_reg <= hot_reg + 1'b1;
                        if (run_reg)
                            streak_reg <= streak_reg + 1'b1;
                    end
                    else
                        run_reg <= 1'b0;
                end
            end
        end
    end

    shamu_div #(
        .SUM_W (SUM_W),
        .CNT_W (FILL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_end),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ---------------- result ----------------
    assign checked = records_reg >= consec_reg;

    always_comb
    begin
        priority if (!checked)
            level = ALERT_NONE;
        else if (hot_reg < consec_reg)
            level = ALERT_NORMAL;
        else if (streak_reg >= consec_reg)
            level = ALERT_RED;
        else
            level = ALERT_YELLOW;
    end

    always_comb
    begin
        out_data_next.has_average = count_reg != '0;
        out_data_next.average     = (count_reg != '0) ? div_quot : 8'sd0;
        out_data_next.alert_level = level;
        out_data_next.hot_count   = checked ? hot_reg : 7'd0;
        out_data_next.found_count = checked ? found_reg : 7'd0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat without a finished query");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(state_reg == ST_SCAN))
        else $error("store read returned outside a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> streak_reg <= hot_reg && hot_reg <= found_reg)
        else $error("alert counters out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_FILL)
        else $error("fill count past store depth");
`endif

endmodule
